>>> hdl/positional_array_list_macros.svh
// assertion macros shared by the list modules
`ifndef POSITIONAL_ARRAY_LIST_MACROS_SVH
`define POSITIONAL_ARRAY_LIST_MACROS_SVH

// same-cycle implication, checked outside reset
`define PAL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define PAL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/pal_pkg.sv
`timescale 1ns / 1ps
package pal_pkg;

    // list capacity and widths; only the index width is derived
    localparam int LP_DEPTH  = 32;
    localparam int LP_IDX_W  = $clog2(LP_DEPTH);
    localparam int LP_CNT_W  = 6;
    localparam int LP_POS_W  = 6;
    localparam int LP_WORD_W = 32;

    // request kinds
    typedef enum logic [1:0] {
        OP_READ   = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2
    } t_op;

    // result status codes
    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_BADPOS = 2'd2
    } t_status;

    // controller states
    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic exec;
    } t_cmd;

endpackage

>>> hdl/pal_ctrl.sv
`timescale 1ns / 1ps
`include "positional_array_list_macros.svh"
module pal_ctrl
    import pal_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    // result register can take a new word
    assign w_out_free = !r_out_valid || i_m_tready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and commands
    always_comb begin
        o_s_tready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            S_EXEC: begin
                o_cmd.exec = w_out_free;
            end
            default: o_s_tready = 1'b0;
        endcase
    end

    // result valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.exec) n_out_valid = 1'b1;
        else if (i_m_tready) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;

    // checks
    `PAL_ASSERT_NEXT(a_accept_exec, i_s_tvalid && o_s_tready, r_state == S_EXEC, "accept not followed by exec")
    `PAL_ASSERT_NOW(a_no_overwrite, o_cmd.exec, !r_out_valid || i_m_tready, "pending result overwritten")
    `PAL_ASSERT_NEXT(a_exec_valid, o_cmd.exec, r_out_valid, "exec did not raise result valid")
    `PAL_ASSERT_NOW(a_busy_stall, r_state == S_EXEC, !o_s_tready, "input taken while busy")

endmodule

>>> hdl/pal_datapath.sv
`timescale 1ns / 1ps
`include "positional_array_list_macros.svh"
module pal_datapath
    import pal_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    input  logic [1:0]           i_op,
    input  logic [LP_POS_W-1:0]  i_pos,
    input  logic [LP_WORD_W-1:0] i_val,
    output logic [LP_WORD_W-1:0] o_word,
    output logic [1:0]           o_status,
    output logic [LP_CNT_W-1:0]  o_count
);

    localparam logic [LP_CNT_W-1:0] LP_DEPTH_C = LP_CNT_W'(LP_DEPTH);

    logic [LP_WORD_W-1:0] r_cells [LP_DEPTH];
    logic [LP_WORD_W-1:0] n_cells [LP_DEPTH];
    logic [1:0]           r_op;
    logic [LP_POS_W-1:0]  r_pos;
    logic [LP_WORD_W-1:0] r_val;
    logic [LP_CNT_W-1:0]  r_count, n_count;
    logic [LP_WORD_W-1:0] r_word, n_word;
    t_status              r_status, n_status;
    logic [LP_POS_W-1:0]  w_pos_m1;
    logic [LP_IDX_W-1:0]  w_idx;
    logic                 w_pos_in;
    logic                 w_pos_app;
    logic                 w_do_ins;
    logic                 w_do_del;

    // position checks against the current length
    assign w_pos_m1  = r_pos - LP_POS_W'(1);
    assign w_idx     = w_pos_m1[LP_IDX_W-1:0];
    assign w_pos_in  = (r_pos != '0) && ({1'b0, r_pos} <= {1'b0, r_count});
    assign w_pos_app = (r_pos != '0) && ({1'b0, r_pos} <= ({1'b0, r_count} + 7'd1));

    // decode request into status, word and shift action
    always_comb begin
        n_word   = '0;
        n_status = STAT_OK;
        n_count  = r_count;
        w_do_ins = 1'b0;
        w_do_del = 1'b0;
        unique case (t_op'(r_op))
            OP_READ: begin
                if (w_pos_in) n_word = r_cells[w_idx];
                else n_status = STAT_BADPOS;
            end
            OP_INSERT: begin
                if (r_count >= LP_DEPTH_C) begin
                    n_status = STAT_FULL;
                end else if (!w_pos_app) begin
                    n_status = STAT_BADPOS;
                end else begin
                    w_do_ins = 1'b1;
                    n_count  = r_count + LP_CNT_W'(1);
                end
            end
            OP_DELETE: begin
                if (w_pos_in) begin
                    w_do_del = 1'b1;
                    n_count  = r_count - LP_CNT_W'(1);
                end else begin
                    n_status = STAT_BADPOS;
                end
            end
            default: n_status = STAT_BADPOS;
        endcase
    end

    // row of cells: each cell holds, takes its lower or upper neighbour, or takes the new word
    always_comb begin
        for (int k = 0; k < LP_DEPTH; k++) begin
            n_cells[k] = r_cells[k];
        end
        if (w_do_ins) begin
            if (w_pos_m1 == '0) n_cells[0] = r_val;
            for (int k = 1; k < LP_DEPTH; k++) begin
                if (LP_POS_W'(k) == w_pos_m1) n_cells[k] = r_val;
                else if (LP_POS_W'(k) > w_pos_m1) n_cells[k] = r_cells[k-1];
            end
        end else if (w_do_del) begin
            for (int k = 0; k < LP_DEPTH - 1; k++) begin
                if (LP_POS_W'(k) >= w_pos_m1) n_cells[k] = r_cells[k+1];
            end
        end
    end

    // request capture, cells and result words
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_op;
            r_pos <= i_pos;
            r_val <= i_val;
        end
        if (i_cmd.exec) begin
            r_cells  <= n_cells;
            r_word   <= n_word;
            r_status <= n_status;
        end
    end

    // list length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    assign o_word   = r_word;
    assign o_status = r_status;
    assign o_count  = r_count;

    // checks
    `PAL_ASSERT_NOW(a_count_bound, 1'b1, r_count <= LP_DEPTH_C, "length beyond capacity")
    `PAL_ASSERT_NEXT(a_count_hold, !i_cmd.exec, r_count == $past(r_count), "length moved without exec")

endmodule

>>> hdl/positional_array_list.sv
`timescale 1ns / 1ps
// channel   dir  tdata                                  tuser
// s (req)   in   [5:0] position, [37:6] value           [1:0] operation
// m (rsp)   out  [31:0] read_word, [37:32] list_count   [1:0] status
//
// each request is captured, then applied in one update of the cell row
// the cells that move all shift in parallel in the update cycle
// a stalled response holds the update cycle until the word is taken
// i_rst_n is synchronous and empties the list; cell contents are not cleared
module positional_array_list
    import pal_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,  // position, value, zero pad
    input  logic [1:0]  i_s_tuser,  // operation
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,  // read_word, list_count, zero pad
    output logic [1:0]  o_m_tuser   // status
);

    t_cmd                 w_cmd;
    logic [LP_WORD_W-1:0] w_word;
    logic [LP_CNT_W-1:0]  w_count;

    // sequencer
    pal_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (w_cmd)
    );

    // cell row and result registers
    pal_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_op     (i_s_tuser),
        .i_pos    (i_s_tdata[5:0]),
        .i_val    (i_s_tdata[37:6]),
        .o_word   (w_word),
        .o_status (o_m_tuser),
        .o_count  (w_count)
    );

    // pack response word
    assign o_m_tdata = {2'b00, w_count, w_word};

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import pal_pkg::*;

    localparam int CLK_PERIOD   = 4;
    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_ITEMS = 1650;
    localparam int MAX_GAP      = 5;
    localparam int HOLD_AT      = 400;     // word count at which the sink backs off
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 10;
    localparam int REPORT_LIMIT = 10;
    localparam int TIMEOUT_NS   = 2_000_000;

    // operation code with no meaning to the block
    localparam logic [1:0] OP_UNKNOWN = 2'd3;

    // random sequence flavours
    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } t_mix;

    typedef struct packed {
        logic [31:0] word;
        t_status     status;
        logic [5:0]  count;
    } t_reply;

    typedef struct {
        logic [1:0]  op;
        logic [5:0]  pos;
        logic [31:0] val;
        int          reps;
        bit          typed;
        t_reply      reply;
    } t_request_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [39:0] i_s_tdata = '0;   // position, value, zero pad
    logic [1:0]  i_s_tuser = '0;   // operation
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [39:0] o_m_tdata;        // read_word, list_count, zero pad
    logic [1:0]  o_m_tuser;        // status

    // own copy of the list
    logic [31:0] list_cells [LP_DEPTH];
    logic [5:0]  list_len = '0;

    t_reply pending_replies [$];
    int     mismatches = 0;
    int     replies_taken = 0;
    bit     quiet_stretch = 1'b0;

    // short directed sequence; typed replies where obvious
    t_request_row directed_rows [25] = '{
        '{OP_READ,    6'd1,  32'h0000_0000, 1,  1, '{32'h0, STAT_BADPOS, 6'd0}},
        '{OP_DELETE,  6'd1,  32'h0000_0000, 1,  1, '{32'h0, STAT_BADPOS, 6'd0}},
        '{OP_INSERT,  6'd0,  32'h1111_1111, 1,  1, '{32'h0, STAT_BADPOS, 6'd0}},
        '{OP_INSERT,  6'd2,  32'h2222_2222, 1,  1, '{32'h0, STAT_BADPOS, 6'd0}},
        '{OP_INSERT,  6'd1,  32'h7FFF_FFFF, 1,  1, '{32'h0, STAT_OK,     6'd1}},
        '{OP_INSERT,  6'd2,  32'h8000_0000, 1,  1, '{32'h0, STAT_OK,     6'd2}},
        '{OP_INSERT,  6'd1,  32'hFFFF_FFFF, 1,  1, '{32'h0, STAT_OK,     6'd3}},
        '{OP_READ,    6'd1,  32'h0000_0000, 1,  1, '{32'hFFFF_FFFF, STAT_OK, 6'd3}},
        '{OP_READ,    6'd3,  32'hFFFF_FFFF, 1,  1, '{32'h8000_0000, STAT_OK, 6'd3}},
        '{OP_READ,    6'd0,  32'h0000_0000, 1,  1, '{32'h0, STAT_BADPOS, 6'd3}},
        '{OP_READ,    6'd4,  32'h0000_0000, 1,  1, '{32'h0, STAT_BADPOS, 6'd3}},
        '{OP_READ,    6'd63, 32'h0000_0000, 1,  1, '{32'h0, STAT_BADPOS, 6'd3}},
        '{OP_UNKNOWN, 6'd1,  32'hFFFF_FFFF, 1,  1, '{32'h0, STAT_BADPOS, 6'd3}},
        '{OP_INSERT,  6'd63, 32'h0000_0000, 1,  1, '{32'h0, STAT_BADPOS, 6'd3}},
        '{OP_DELETE,  6'd2,  32'h0000_0000, 1,  1, '{32'h0, STAT_OK,     6'd2}},
        '{OP_READ,    6'd2,  32'h0000_0000, 1,  1, '{32'h8000_0000, STAT_OK, 6'd2}},
        '{OP_DELETE,  6'd0,  32'h0000_0000, 1,  1, '{32'h0, STAT_BADPOS, 6'd2}},
        '{OP_DELETE,  6'd3,  32'h0000_0000, 1,  1, '{32'h0, STAT_BADPOS, 6'd2}},
        '{OP_INSERT,  6'd2,  32'h5A5A_A5A5, 1,  0, '{32'h0, STAT_OK,     6'd0}},
        '{OP_INSERT,  6'd1,  32'h1234_5678, 29, 0, '{32'h0, STAT_OK,     6'd0}},
        '{OP_INSERT,  6'd33, 32'h0000_0000, 1,  1, '{32'h0, STAT_FULL,   6'd32}},
        '{OP_INSERT,  6'd0,  32'h0000_0000, 1,  1, '{32'h0, STAT_FULL,   6'd32}},
        '{OP_READ,    6'd32, 32'h0000_0000, 1,  0, '{32'h0, STAT_OK,     6'd0}},
        '{OP_DELETE,  6'd32, 32'h0000_0000, 2,  0, '{32'h0, STAT_OK,     6'd0}},
        '{OP_DELETE,  6'd1,  32'h0000_0000, 30, 0, '{32'h0, STAT_OK,     6'd0}}
    };

    positional_array_list i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // clock
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // apply one request to the local list and return the reply it should give
    function automatic t_reply apply_request(logic [1:0] op, logic [5:0] pos,
                                             logic [31:0] val);
        t_reply r;
        int     len;
        int     p;
        r.word   = '0;
        r.status = STAT_OK;
        len      = int'(list_len);
        p        = int'(pos);
        case (op)
            OP_READ: begin
                if (p < 1 || p > len) r.status = STAT_BADPOS;
                else r.word = list_cells[p - 1];
            end
            OP_INSERT: begin
                if (len >= LP_DEPTH) begin
                    r.status = STAT_FULL;
                end else if (p < 1 || p > len + 1) begin
                    r.status = STAT_BADPOS;
                end else begin
                    for (int k = len; k >= p; k--) list_cells[k] = list_cells[k - 1];
                    list_cells[p - 1] = val;
                    list_len = list_len + 6'd1;
                end
            end
            OP_DELETE: begin
                if (p < 1 || p > len) begin
                    r.status = STAT_BADPOS;
                end else begin
                    for (int k = p; k < len; k++) list_cells[k - 1] = list_cells[k];
                    list_len = list_len - 6'd1;
                end
            end
            default: r.status = STAT_BADPOS;
        endcase
        r.count = list_len;
        return r;
    endfunction

    // offer one request, entered and left at a falling edge
    task automatic send_request(logic [1:0] op, logic [5:0] pos, logic [31:0] val,
                                bit typed, t_reply typed_reply);
        int     gap;
        t_reply want;
        gap = quiet_stretch ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {2'b00, val, pos};
        i_s_tuser  <= op;
        do @(posedge i_clk); while (!o_s_tready);
        want = apply_request(op, pos, val);
        if (typed) want = typed_reply;
        pending_replies.push_back(want);
        @(negedge i_clk);
    endtask

    // position mostly inside the range that the operation accepts
    function automatic logic [5:0] pick_position(logic [1:0] op);
        int top;
        top = (op == OP_INSERT) ? int'(list_len) + 1 : int'(list_len);
        if (top > LP_DEPTH) top = LP_DEPTH;
        if (top < 1 || $urandom_range(0, 99) < 12) return 6'($urandom_range(0, 63));
        return 6'($urandom_range(1, top));
    endfunction

    function automatic logic [1:0] pick_operation(t_mix mix);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 2) return OP_UNKNOWN;
        case (mix)
            MIX_FILL:  return (roll < 75) ? OP_INSERT : (roll < 90) ? OP_READ : OP_DELETE;
            MIX_DRAIN: return (roll < 70) ? OP_DELETE : (roll < 85) ? OP_READ : OP_INSERT;
            default:   return (roll < 35) ? OP_INSERT : (roll < 70) ? OP_DELETE : OP_READ;
        endcase
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // response sink: random back-pressure, one long hold-off
    task automatic take_replies();
        int stall;
        forever begin
            stall = quiet_stretch ? 0 : $urandom_range(0, MAX_GAP);
            if (replies_taken == HOLD_AT) stall = HOLD_CYCLES;
            if (stall != 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            @(negedge i_clk);
        end
    endtask

    // compare each reply word with the oldest outstanding one
    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            replies_taken <= replies_taken + 1;
            if (pending_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("reply word with nothing outstanding: word %h status %0d count %0d",
                             o_m_tdata[31:0], o_m_tuser, o_m_tdata[37:32]);
            end else begin
                want = pending_replies.pop_front();
                if (o_m_tdata[31:0] !== want.word || o_m_tuser !== want.status
                        || o_m_tdata[37:32] !== want.count) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("reply mismatch: want %h/%0d/%0d got %h/%0d/%0d",
                                 want.word, want.status, want.count,
                                 o_m_tdata[31:0], o_m_tuser, o_m_tdata[37:32]);
                end
            end
        end
    end

    // run limit
    initial begin
        #(TIMEOUT_NS);
        $display("testbench: errors");
        $finish;
    end

    // reset, directed rows, random sequences, drain
    initial begin
        int   sent;
        int   seg_len;
        t_mix mix;
        logic [1:0] op;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        fork
            take_replies();
        join_none

        foreach (directed_rows[r]) begin
            for (int n = 0; n < directed_rows[r].reps; n++)
                send_request(directed_rows[r].op, directed_rows[r].pos, directed_rows[r].val,
                             directed_rows[r].typed, directed_rows[r].reply);
        end

        // let the block empty before the random part
        i_s_tvalid <= 1'b0;
        while (pending_replies.size() != 0) @(negedge i_clk);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            seg_len       = $urandom_range(20, 80);
            mix           = t_mix'($urandom_range(0, 2));
            quiet_stretch = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 5) == 0) begin
                i_s_tvalid <= 1'b0;
                while (pending_replies.size() != 0) @(negedge i_clk);
            end
            for (int n = 0; n < seg_len && sent < RANDOM_ITEMS; n++) begin
                op = pick_operation(mix);
                send_request(op, pick_position(op), pick_value(), 1'b0, '0);
                sent++;
            end
        end
        i_s_tvalid <= 1'b0;
        quiet_stretch = 1'b0;

        while (pending_replies.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && pending_replies.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

>>> sim.f
+incdir+hdl
hdl/pal_pkg.sv
hdl/pal_ctrl.sv
hdl/pal_datapath.sv
hdl/positional_array_list.sv
bench/testbench.sv
